// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the camera step RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define FCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be true outside reset
`define FCS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/fcs_pkg.sv -----
// Types, constants and saturation helpers for the camera step block
package fcs_pkg;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned SqSteps = 31;
  localparam int unsigned DvSteps = 31;

  localparam logic CfgMinDist = 1'b0;
  localparam logic CfgGround  = 1'b1;

  localparam logic signed [33:0] S32MaxW = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] S32MinW = -34'sh0_8000_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               moved;
  } item_t;

  typedef struct packed {
    item_t      item;
    logic [2:0] neg;
    logic       push;
  } ctx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               pushed;
    logic               clamped;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S32MaxW) r = 32'sh7FFF_FFFF;
    else if (v < S32MinW) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic [31:0] b,
                                                 input logic sub);
    logic signed [33:0] aw;
    logic signed [33:0] bw;
    aw = {a[31], a[31], a};
    bw = {2'b00, b};
    return sat32(sub ? aw - bw : aw + bw);
  endfunction

endpackage

// ----- hw/rtl/free_camera_step_with_standoff.sv -----
// Free camera step with player standoff: top level and configuration registers
//
// Takes one item per cycle while in_stall_o is low and returns one result per item, in order.
// An item passes the front input register and the queue, then the back end's offset, square
// and sum stages, a 31-step square root line, a 31-step divider line (three lanes) and the
// output register. The depth of the square root and divider lines sets the latency; every
// stage advances each cycle the output is free, so throughput is one item per cycle while
// out_stall_i does not hold the output. A four-entry queue lets the front keep taking items
// while the output is stalled. Registers: index 0 min_distance (data[30:0]), index 1
// ground_level; cfg_ready_o is always high.
module free_camera_step_with_standoff (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] cam_x_i,
  input  logic signed [31:0] cam_y_i,
  input  logic signed [31:0] cam_z_i,
  input  logic signed [31:0] player_x_i,
  input  logic signed [31:0] player_y_i,
  input  logic signed [31:0] player_z_i,
  input  logic [5:0]         direction_keys_i,
  input  logic signed [31:0] move_speed_i,
  input  logic [19:0]        delta_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  output logic               pushed_out_o,
  output logic               ground_clamped_o
);

  logic [30:0]        md_q;
  logic [61:0]        md_sq_q;
  logic signed [31:0] gl_q;

  logic           q_full, q_push, q_pop, q_empty;
  fcs_pkg::item_t f_item, q_item;
  fcs_pkg::res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q    <= '0;
      md_sq_q <= '0;
      gl_q    <= 32'sh8000_0000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fcs_pkg::CfgMinDist: begin
          md_q    <= cfg_data_i[30:0];
          md_sq_q <= 62'(cfg_data_i[30:0]) * 62'(cfg_data_i[30:0]);
        end
        fcs_pkg::CfgGround: begin
          gl_q <= cfg_data_i;
        end
        default: begin
          gl_q <= gl_q;
        end
      endcase
    end
  end

  fcs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cam_x_i          (cam_x_i),
    .cam_y_i          (cam_y_i),
    .cam_z_i          (cam_z_i),
    .player_x_i       (player_x_i),
    .player_y_i       (player_y_i),
    .player_z_i       (player_z_i),
    .direction_keys_i (direction_keys_i),
    .move_speed_i     (move_speed_i),
    .delta_time_i     (delta_time_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_item_o         (f_item)
  );

  fcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  fcs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .md_i           (md_q),
    .md_sq_i        (md_sq_q),
    .ground_level_i (gl_q),
    .q_empty_i      (q_empty),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .res_o          (res)
  );

  assign new_x_o          = res.x;
  assign new_y_o          = res.y;
  assign new_z_o          = res.z;
  assign pushed_out_o     = res.pushed;
  assign ground_clamped_o = res.clamped;

endmodule

// ----- hw/rtl/fcs_front.sv -----
// Front end: input register, displacement product and per-axis key moves
module fcs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] cam_x_i,
  input  logic signed [31:0] cam_y_i,
  input  logic signed [31:0] cam_z_i,
  input  logic signed [31:0] player_x_i,
  input  logic signed [31:0] player_y_i,
  input  logic signed [31:0] player_z_i,
  input  logic [5:0]         direction_keys_i,
  input  logic signed [31:0] move_speed_i,
  input  logic [19:0]        delta_time_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output fcs_pkg::item_t     q_item_o
);

  logic               f_v_q, f_v_d;
  fcs_pkg::item_t     raw_q;
  logic [5:0]         keys_q;
  logic [50:0]        prod_q;
  logic               accept;
  logic [31:0]        disp;
  logic signed [31:0] y1, y2, x1, x2, z1, z2;

  assign in_stall_o = f_v_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = f_v_q & ~q_full_i;
  assign f_v_d      = accept | (f_v_q & q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= f_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q.x     <= cam_x_i;
      raw_q.y     <= cam_y_i;
      raw_q.z     <= cam_z_i;
      raw_q.px    <= player_x_i;
      raw_q.py    <= player_y_i;
      raw_q.pz    <= player_z_i;
      raw_q.moved <= ~move_speed_i[31] & (|move_speed_i[30:0]);
      keys_q      <= direction_keys_i;
      prod_q      <= 51'(move_speed_i[30:0]) * 51'(delta_time_i);
    end
  end

  always_comb begin
    disp = (|prod_q[50:47]) ? 32'h7FFF_FFFF : {1'b0, prod_q[46:16]};
    y1 = keys_q[0] ? fcs_pkg::add_sat(raw_q.y, disp, 1'b0) : raw_q.y;
    y2 = keys_q[1] ? fcs_pkg::add_sat(y1, disp, 1'b1) : y1;
    x1 = keys_q[2] ? fcs_pkg::add_sat(raw_q.x, disp, 1'b1) : raw_q.x;
    x2 = keys_q[3] ? fcs_pkg::add_sat(x1, disp, 1'b0) : x1;
    z1 = keys_q[4] ? fcs_pkg::add_sat(raw_q.z, disp, 1'b0) : raw_q.z;
    z2 = keys_q[5] ? fcs_pkg::add_sat(z1, disp, 1'b1) : z1;
    q_item_o = raw_q;
    if (raw_q.moved) begin
      q_item_o.x = x2;
      q_item_o.y = y2;
      q_item_o.z = z2;
    end
  end

endmodule

// ----- hw/rtl/fcs_queue.sv -----
// Short FIFO between front end and back end
`include "assert_macros.svh"
module fcs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcs_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fcs_pkg::item_t item_o
);

  localparam int unsigned PtrW = $clog2(fcs_pkg::QDepth);
  localparam int unsigned CntW = $clog2(fcs_pkg::QDepth + 1);

  fcs_pkg::item_t mem_q [fcs_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(fcs_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `FCS_NEVER(a_push_full, push_i && full_o && !pop_i, "transfer into full queue")
  `FCS_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty queue")

endmodule

// ----- hw/rtl/fcs_back.sv -----
// Back end: offsets, squares, square root, scaling divide, saturation, ground clamp
`include "assert_macros.svh"
module fcs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [30:0]        md_i,
  input  logic [61:0]        md_sq_i,
  input  logic signed [31:0] ground_level_i,
  input  logic               q_empty_i,
  input  fcs_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fcs_pkg::res_t      res_o
);

  localparam int unsigned SQ = fcs_pkg::SqSteps;
  localparam int unsigned DV = fcs_pkg::DvSteps;

  logic en;
  logic out_valid_q;
  fcs_pkg::res_t out_q;

  assign en          = ~out_valid_q | ~out_stall_i;
  assign q_pop_o     = en & ~q_empty_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  // stage A: offsets
  logic               a_v_q;
  fcs_pkg::item_t     a_item_q;
  logic [2:0]         a_neg_q;
  logic [2:0]         a_near_q;
  logic [2:0][30:0]   a_mag_q;
  logic signed [32:0] d [3];
  logic [32:0]        m [3];

  always_comb begin
    d[0] = {q_item_i.x[31], q_item_i.x} - {q_item_i.px[31], q_item_i.px};
    d[1] = {q_item_i.y[31], q_item_i.y} - {q_item_i.py[31], q_item_i.py};
    d[2] = {q_item_i.z[31], q_item_i.z} - {q_item_i.pz[31], q_item_i.pz};
    for (int j = 0; j < 3; j++) begin
      m[j] = d[j][32] ? 33'(-d[j]) : 33'(d[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q <= q_item_i;
      for (int j = 0; j < 3; j++) begin
        a_neg_q[j]  <= d[j][32];
        a_mag_q[j]  <= m[j][30:0];
        a_near_q[j] <= (m[j] < {2'b00, md_i});
      end
    end
  end

  // stage B: squares and numerators
  logic             b_v_q;
  fcs_pkg::ctx_t    b_ctx_q;
  logic             b_near_q;
  logic [2:0][61:0] b_sq_q, b_n_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ctx_q.item <= a_item_q;
      b_ctx_q.neg  <= a_neg_q;
      b_ctx_q.push <= 1'b0;
      b_near_q     <= (&a_near_q) & (md_i != '0);
      for (int j = 0; j < 3; j++) begin
        b_sq_q[j] <= 62'(a_mag_q[j]) * 62'(a_mag_q[j]);
        b_n_q[j]  <= 62'(a_mag_q[j]) * 62'(md_i);
      end
    end
  end

  // stage C: sum and push decision, start of square root line
  logic [63:0]       ss;
  logic [SQ:0]       s_v_q;
  fcs_pkg::ctx_t     s_ctx_q  [SQ+1];
  logic [2:0][61:0]  s_n_q    [SQ+1];
  logic [33:0]       s_rem_q  [SQ+1];
  logic [30:0]       s_root_q [SQ+1];
  logic [61:0]       s_val_q  [SQ+1];

  assign ss = 64'(b_sq_q[0]) + 64'(b_sq_q[1]) + 64'(b_sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_ctx_q[0].item <= b_ctx_q.item;
      s_ctx_q[0].neg  <= b_ctx_q.neg;
      s_ctx_q[0].push <= b_ctx_q.item.moved & b_near_q & (ss != '0)
                         & (ss < {2'b00, md_sq_i});
      s_n_q[0]        <= b_n_q;
      s_rem_q[0]      <= '0;
      s_root_q[0]     <= '0;
      s_val_q[0]      <= ss[61:0];
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [35:0] remw, trial;
    logic        ge;
    always_comb begin
      remw  = {s_rem_q[k], s_val_q[k][61:60]};
      trial = {3'b000, s_root_q[k], 2'b01};
      ge    = (remw >= trial);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_ctx_q[k+1]  <= s_ctx_q[k];
        s_n_q[k+1]    <= s_n_q[k];
        s_rem_q[k+1]  <= ge ? 34'(remw - trial) : remw[33:0];
        s_root_q[k+1] <= {s_root_q[k][29:0], ge};
        s_val_q[k+1]  <= {s_val_q[k][59:0], 2'b00};
      end
    end
  end

  // restoring divide line, three lanes
  logic [DV:0]      d_v_q;
  fcs_pkg::ctx_t    d_ctx_q  [DV+1];
  logic [30:0]      d_dist_q [DV+1];
  logic [2:0][30:0] d_rem_q  [DV+1];
  logic [2:0][30:0] d_n_q    [DV+1];
  logic [2:0][30:0] d_quo_q  [DV+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ctx_q[0]  <= s_ctx_q[SQ];
      d_dist_q[0] <= s_root_q[SQ];
      for (int j = 0; j < 3; j++) begin
        d_rem_q[0][j] <= s_n_q[SQ][j][61:31];
        d_n_q[0][j]   <= s_n_q[SQ][j][30:0];
        d_quo_q[0][j] <= '0;
      end
    end
  end

  for (genvar k = 0; k < DV; k++) begin : g_div
    logic [2:0][31:0] t;
    logic [2:0]       ge;
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        t[j]  = {d_rem_q[k][j], d_n_q[k][j][30]};
        ge[j] = (t[j] >= {1'b0, d_dist_q[k]});
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_ctx_q[k+1]  <= d_ctx_q[k];
        d_dist_q[k+1] <= d_dist_q[k];
        for (int j = 0; j < 3; j++) begin
          d_rem_q[k+1][j] <= ge[j] ? 31'(t[j] - {1'b0, d_dist_q[k]}) : t[j][30:0];
          d_n_q[k+1][j]   <= {d_n_q[k][j][29:0], 1'b0};
          d_quo_q[k+1][j] <= {d_quo_q[k][j][29:0], ge[j]};
        end
      end
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      s_v_q       <= '0;
      d_v_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_v_q       <= q_pop_o;
      b_v_q       <= a_v_q;
      s_v_q       <= {s_v_q[SQ-1:0], b_v_q};
      d_v_q       <= {d_v_q[DV-1:0], s_v_q[SQ]};
      out_valid_q <= d_v_q[DV];
    end
  end

  // final: add back to player, saturate, ground clamp
  fcs_pkg::ctx_t      fc;
  logic signed [31:0] pc  [3];
  logic signed [31:0] pv  [3];
  logic signed [33:0] off [3];
  fcs_pkg::res_t      out_d;

  always_comb begin
    fc    = d_ctx_q[DV];
    pc[0] = fc.item.px;
    pc[1] = fc.item.py;
    pc[2] = fc.item.pz;
    for (int j = 0; j < 3; j++) begin
      off[j] = fc.neg[j] ? -{3'b000, d_quo_q[DV][j]} : {3'b000, d_quo_q[DV][j]};
      pv[j]  = fcs_pkg::sat32({pc[j][31], pc[j][31], pc[j]} + off[j]);
    end
    out_d.x       = fc.push ? pv[0] : fc.item.x;
    out_d.y       = fc.push ? pv[1] : fc.item.y;
    out_d.z       = fc.push ? pv[2] : fc.item.z;
    out_d.pushed  = fc.push;
    out_d.clamped = fc.item.moved & (out_d.z < ground_level_i);
    if (out_d.clamped) out_d.z = ground_level_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  `FCS_ASSERT(a_out_hold, out_valid_q && out_stall_i |=> out_valid_q, "result dropped")
  `FCS_ASSERT(a_clamp_z, out_valid_q && out_q.clamped |-> out_q.z == ground_level_i,
              "clamped z differs from ground level")

endmodule
